/* hw/rtl/dlle_pkg.sv */
`timescale 1ns / 1ps

package dlle_pkg;

   // request codes
   localparam logic [2:0] REQ_CLEAR    = 3'd0;
   localparam logic [2:0] REQ_HEAD_INS = 3'd1;
   localparam logic [2:0] REQ_TAIL_INS = 3'd2;
   localparam logic [2:0] REQ_POS_INS  = 3'd3;
   localparam logic [2:0] REQ_FIND     = 3'd4;
   localparam logic [2:0] REQ_REMOVE   = 3'd5;
   localparam logic [2:0] REQ_DUMP     = 3'd6;
   localparam logic [2:0] REQ_RDUMP    = 3'd7;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_CLAMPED   = 2'd3;

   // classified request as it sits in the queue (value travels beside it)
   typedef struct packed {
      logic [2:0] kind;
      logic [6:0] pos;    // zero already mapped to one
   } cmd_type;

   // one result transfer
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] item_value;
      logic        item_valid;
      logic [6:0]  found_index;
      logic [6:0]  list_count;
      logic        last_of_run;
   } rsp_type;

endpackage

/* hw/rtl/dlle_front.sv */
`timescale 1ns / 1ps

module dlle_front #(
   parameter int VALUE_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [2:0]              req_type,
   input  logic signed [31:0]      req_value,
   input  logic [6:0]              req_position,
   output logic                    q_valid,
   input  logic                    q_pop,
   output dlle_pkg::cmd_type       q_cmd,
   output logic [VALUE_BITS-1:0]   q_value
);
   import dlle_pkg::*;

   cmd_type               cmd_mem [2];
   logic [VALUE_BITS-1:0] val_mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   cmd_type    cmd_new;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_cmd     = cmd_mem[rd_ptr_ff];
   assign q_value   = val_mem[rd_ptr_ff];

   // classify: position zero means the head slot
   always_comb begin
      cmd_new.kind = req_type;
      cmd_new.pos  = (req_position == 7'd0) ? 7'd1 : req_position;
   end

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = (q_pop && q_valid) ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage; value kept sign-extended or cut to the stored width
   always_ff @(posedge clock) begin
      if (push) begin
         cmd_mem[wr_ptr_ff] <= cmd_new;
         val_mem[wr_ptr_ff] <= VALUE_BITS'(req_value);
      end
   end

endmodule

/* hw/rtl/dlle_back.sv */
`timescale 1ns / 1ps

module dlle_back #(
   parameter int POOL_NODES = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   output logic                    q_pop,
   input  dlle_pkg::cmd_type       q_cmd,
   input  logic [VALUE_BITS-1:0]   q_value,
   output logic                    out_valid,
   input  logic                    out_ready,
   output dlle_pkg::rsp_type       out_rsp
);
   import dlle_pkg::*;

   localparam int IW = $clog2(POOL_NODES + 1);
   localparam int AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
   localparam logic [IW-1:0] NULL_IDX = IW'(POOL_NODES);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_WALK_RD = 4'd1;
   localparam logic [3:0] S_WALK    = 4'd2;
   localparam logic [3:0] S_LINK_RD = 4'd3;
   localparam logic [3:0] S_LINK_NX = 4'd4;
   localparam logic [3:0] S_LINK_A  = 4'd5;
   localparam logic [3:0] S_LINK_B  = 4'd6;
   localparam logic [3:0] S_SRCH_RD = 4'd7;
   localparam logic [3:0] S_SRCH    = 4'd8;
   localparam logic [3:0] S_UNLINK  = 4'd9;
   localparam logic [3:0] S_DUMP_RD = 4'd10;
   localparam logic [3:0] S_DUMP    = 4'd11;
   localparam logic [3:0] S_RESP    = 4'd12;

   // node pool
   logic [VALUE_BITS-1:0] val_mem [POOL_NODES];
   logic [IW-1:0]         fwd_mem [POOL_NODES];
   logic [IW-1:0]         bwd_mem [POOL_NODES];
   logic [VALUE_BITS-1:0] rd_val_ff;
   logic [IW-1:0]         rd_fwd_ff, rd_bwd_ff;

   logic [3:0]            state_ff, state_in;
   logic [2:0]            kind_ff, kind_in;
   logic [VALUE_BITS-1:0] v_ff, v_in;
   logic [IW-1:0]         c_ff, c_in;
   logic [IW-1:0]         nx_ff, nx_in;
   logic [6:0]            steps_ff, steps_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic [IW-1:0]         k_ff, k_in;
   logic [1:0]            status_ff, status_in;
   logic [IW-1:0]         found_ff, found_in;
   logic [IW-1:0]         first_ff, first_in;
   logic [IW-1:0]         last_ff, last_in;
   logic [IW-1:0]         taken_ff, taken_in;
   logic [IW-1:0]         total_ff, total_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff, out_in;

   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic                  val_we, fwd_we, bwd_we;
   logic [AW-1:0]         val_wa, fwd_wa, bwd_wa;
   logic [IW-1:0]         fwd_wd, bwd_wd;
   logic                  slot_free, full, c_live, dump_last;
   logic [IW-1:0]         dump_next;

   assign slot_free = !out_valid_ff || out_ready;
   assign full      = (taken_ff == NULL_IDX);
   assign c_live    = (c_ff != NULL_IDX);
   assign out_valid = out_valid_ff;
   assign out_rsp   = out_ff;
   assign dump_next = (kind_ff == REQ_DUMP) ? rd_fwd_ff : rd_bwd_ff;
   assign dump_last = (dump_next == NULL_IDX) || ((k_ff + 1'b1) == total_ff);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      v_in         = v_ff;
      c_in         = c_ff;
      nx_in        = nx_ff;
      steps_in     = steps_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      taken_in     = taken_ff;
      total_in     = total_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_in       = out_ff;
      q_pop        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = c_ff[AW-1:0];
      val_we       = 1'b0;
      fwd_we       = 1'b0;
      bwd_we       = 1'b0;
      val_wa       = taken_ff[AW-1:0];
      fwd_wa       = taken_ff[AW-1:0];
      bwd_wa       = taken_ff[AW-1:0];
      fwd_wd       = nx_ff;
      bwd_wd       = c_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               kind_in   = q_cmd.kind;
               v_in      = q_value;
               status_in = ST_OK;
               found_in  = '0;
               state_in  = S_RESP;
               unique case (q_cmd.kind)
                  REQ_CLEAR: begin
                     first_in = NULL_IDX;
                     last_in  = NULL_IDX;
                     taken_in = '0;
                     total_in = '0;
                  end
                  REQ_HEAD_INS, REQ_TAIL_INS: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        c_in     = (q_cmd.kind == REQ_HEAD_INS) ? NULL_IDX : last_ff;
                        state_in = S_LINK_RD;
                     end
                  end
                  REQ_POS_INS: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else if ({1'b0, q_cmd.pos} > (8'(total_ff) + 8'd1)) begin
                        status_in = ST_CLAMPED;
                        c_in      = last_ff;
                        state_in  = S_LINK_RD;
                     end else if (q_cmd.pos == 7'd1) begin
                        c_in     = NULL_IDX;
                        state_in = S_LINK_RD;
                     end else begin
                        // first step lands on the head, the rest follow links
                        c_in     = first_ff;
                        steps_in = q_cmd.pos - 7'd2;
                        state_in = (q_cmd.pos == 7'd2) ? S_LINK_RD : S_WALK_RD;
                     end
                  end
                  REQ_FIND, REQ_REMOVE: begin
                     c_in   = first_ff;
                     idx_in = IW'(1);
                     if (first_ff == NULL_IDX) begin
                        status_in = ST_NOT_FOUND;
                     end else begin
                        state_in = S_SRCH_RD;
                     end
                  end
                  REQ_DUMP, REQ_RDUMP: begin
                     c_in = (q_cmd.kind == REQ_DUMP) ? first_ff : last_ff;
                     k_in = '0;
                     if (total_ff != '0) begin
                        state_in = S_DUMP_RD;
                     end
                  end
               endcase
            end
         end
         S_WALK_RD: begin
            rd_en    = 1'b1;
            state_in = S_WALK;
         end
         S_WALK: begin
            c_in     = rd_fwd_ff;
            steps_in = steps_ff - 7'd1;
            state_in = (steps_ff == 7'd1) ? S_LINK_RD : S_WALK_RD;
         end
         S_LINK_RD: begin
            if (c_live) begin
               rd_en    = 1'b1;
               state_in = S_LINK_NX;
            end else begin
               nx_in    = first_ff;
               state_in = S_LINK_A;
            end
         end
         S_LINK_NX: begin
            nx_in    = rd_fwd_ff;
            state_in = S_LINK_A;
         end
         S_LINK_A: begin
            // fill the fresh node
            val_we   = 1'b1;
            fwd_we   = 1'b1;
            bwd_we   = 1'b1;
            state_in = S_LINK_B;
         end
         S_LINK_B: begin
            // hook neighbors onto the fresh node
            fwd_we = c_live;
            fwd_wa = c_ff[AW-1:0];
            fwd_wd = taken_ff;
            bwd_we = (nx_ff != NULL_IDX);
            bwd_wa = nx_ff[AW-1:0];
            bwd_wd = taken_ff;
            if (!c_live) first_in = taken_ff;
            if (nx_ff == NULL_IDX) last_in = taken_ff;
            taken_in = taken_ff + 1'b1;
            total_in = total_ff + 1'b1;
            state_in = S_RESP;
         end
         S_SRCH_RD: begin
            rd_en    = 1'b1;
            state_in = S_SRCH;
         end
         S_SRCH: begin
            if (rd_val_ff == v_ff) begin
               found_in = idx_ff;
               state_in = (kind_ff == REQ_REMOVE) ? S_UNLINK : S_RESP;
            end else if (rd_fwd_ff == NULL_IDX) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_RESP;
            end else begin
               c_in     = rd_fwd_ff;
               idx_in   = idx_ff + 1'b1;
               state_in = S_SRCH_RD;
            end
         end
         S_UNLINK: begin
            fwd_we = (rd_bwd_ff != NULL_IDX);
            fwd_wa = rd_bwd_ff[AW-1:0];
            fwd_wd = rd_fwd_ff;
            bwd_we = (rd_fwd_ff != NULL_IDX);
            bwd_wa = rd_fwd_ff[AW-1:0];
            bwd_wd = rd_bwd_ff;
            if (rd_bwd_ff == NULL_IDX) first_in = rd_fwd_ff;
            if (rd_fwd_ff == NULL_IDX) last_in = rd_bwd_ff;
            total_in = total_ff - 1'b1;
            state_in = S_RESP;
         end
         S_DUMP_RD: begin
            rd_en    = 1'b1;
            state_in = S_DUMP;
         end
         S_DUMP: begin
            if (slot_free) begin
               out_valid_in       = 1'b1;
               out_in.status      = ST_OK;
               out_in.item_value  = 32'(rd_val_ff);
               out_in.item_valid  = 1'b1;
               out_in.found_index = '0;
               out_in.list_count  = 7'(total_ff);
               out_in.last_of_run = dump_last;
               c_in               = dump_next;
               k_in               = k_ff + 1'b1;
               state_in           = dump_last ? S_IDLE : S_DUMP_RD;
            end
         end
         S_RESP: begin
            if (slot_free) begin
               out_valid_in       = 1'b1;
               out_in.status      = status_ff;
               out_in.item_value  = '0;
               out_in.item_valid  = 1'b0;
               out_in.found_index = 7'(found_ff);
               out_in.list_count  = 7'(total_ff);
               out_in.last_of_run = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         first_ff     <= NULL_IDX;
         last_ff      <= NULL_IDX;
         taken_ff     <= '0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         taken_ff     <= taken_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      v_ff      <= v_in;
      c_ff      <= c_in;
      nx_ff     <= nx_in;
      steps_ff  <= steps_in;
      idx_ff    <= idx_in;
      k_ff      <= k_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      out_ff    <= out_in;
   end

   // pool memories: one write each, one shared registered read
   always_ff @(posedge clock) begin
      if (val_we) val_mem[val_wa] <= v_ff;
      if (fwd_we) fwd_mem[fwd_wa] <= fwd_wd;
      if (bwd_we) bwd_mem[bwd_wa] <= bwd_wd;
      if (rd_en) begin
         rd_val_ff <= val_mem[rd_addr];
         rd_fwd_ff <= fwd_mem[rd_addr];
         rd_bwd_ff <= bwd_mem[rd_addr];
      end
   end

endmodule

/* hw/rtl/doubly_linked_list_engine.sv */
`timescale 1ns / 1ps

// Doubly linked list of signed values held in a pool of POOL_NODES nodes.
// A front end takes requests into a two-entry queue; a back end walks the
// node pool, whose value and link memories are read one node at a time
// through a registered read port. Position insert walks links past the
// head one node at a time, find and remove compare nodes in order from the
// head, and a dump sends its elements one by one as it reads them. Result
// stalls hold the back end. Nodes are not reclaimed until the next clear;
// no clearing pass is needed after reset.
module doubly_linked_list_engine #(
   parameter int POOL_NODES = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_type,
   input  logic signed [31:0] req_value,
   input  logic [6:0]         req_position,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_item_value,
   output logic               rsp_item_valid,
   output logic [6:0]         rsp_found_index,
   output logic [6:0]         rsp_list_count,
   output logic               rsp_last_of_run
);
   import dlle_pkg::*;

   logic                  q_valid, q_pop;
   cmd_type               q_cmd;
   logic [VALUE_BITS-1:0] q_value;
   rsp_type               rsp;

   dlle_front #(.VALUE_BITS(VALUE_BITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_type     (req_type),
      .req_value    (req_value),
      .req_position (req_position),
      .q_valid      (q_valid),
      .q_pop        (q_pop),
      .q_cmd        (q_cmd),
      .q_value      (q_value)
   );

   dlle_back #(.POOL_NODES(POOL_NODES), .VALUE_BITS(VALUE_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_cmd     (q_cmd),
      .q_value   (q_value),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_rsp   (rsp)
   );

   // unpack the result transfer
   assign rsp_status      = rsp.status;
   assign rsp_item_value  = rsp.item_value;
   assign rsp_item_valid  = rsp.item_valid;
   assign rsp_found_index = rsp.found_index;
   assign rsp_list_count  = rsp.list_count;
   assign rsp_last_of_run = rsp.last_of_run;

endmodule

/* hw/rtl/dlle_checker.sv */
`timescale 1ns / 1ps

module dlle_checker #(
   parameter int POOL_NODES = 64
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic        rsp_item_valid,
   input logic [6:0]  rsp_found_index,
   input logic [6:0]  rsp_list_count,
   input logic        rsp_last_of_run
);
   import dlle_pkg::*;

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // dump elements carry ok status and no index
   a_item_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_valid |-> rsp_status == ST_OK && rsp_found_index == 7'd0)
      else $error("dump element with status or index");

   // single results always close their request
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item_valid |-> rsp_last_of_run)
      else $error("non-element result not marked last");

   // count never exceeds the pool; a removed match may sit one past the count
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_list_count <= 7'(POOL_NODES)
                    && {1'b0, rsp_found_index} <= ({1'b0, rsp_list_count} + 8'd1))
      else $error("count or index out of range");

endmodule

bind doubly_linked_list_engine dlle_checker #(.POOL_NODES(POOL_NODES)) u_dlle_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_item_valid  (rsp_item_valid),
   .rsp_found_index (rsp_found_index),
   .rsp_list_count  (rsp_list_count),
   .rsp_last_of_run (rsp_last_of_run)
);
